>>> hdl/motor_fader_pid_controller_macros.svh
// Assertion macros for the motor fader PID controller.
`ifndef MOTOR_FADER_PID_CONTROLLER_MACROS_SVH
`define MOTOR_FADER_PID_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, held off while reset is low.
`define MFP_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Clocked check that also holds through reset.
`define MFP_ASSERT_NR(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define MFP_ASSERT(name, prop)
`define MFP_ASSERT_NR(name, prop)
`endif
`endif

>>> hdl/mfp_pkg.sv
// Shared widths, constants and command types of the motor fader PID controller.
`default_nettype none
package mfp_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned GAIN_W     = 20;
  localparam int unsigned SMOOTH_W   = 9;
  localparam int unsigned STIC_W     = 7;
  localparam int unsigned LIM_W      = 20;
  localparam int unsigned WIN_W      = 13;
  localparam int unsigned Q8_SH      = 8;
  localparam int unsigned Q24_SH     = 24;
  localparam int unsigned AVG_W      = SAMPLE_W + Q8_SH;
  localparam int unsigned ERR_W      = AVG_W + 1;
  localparam int unsigned ABS_W      = ERR_W - 1;
  localparam int unsigned DERIV_W    = ERR_W + 1;
  localparam int unsigned ESUM_W     = 30;
  localparam int unsigned MUL_A_W    = GAIN_W + 1;
  localparam int unsigned MUL_B_W    = ESUM_W;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W      = PROD_W + 1;
  localparam int unsigned QUO_W      = ACC_W - Q24_SH;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned PERR_W     = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_STICTION     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_INT_WINDOW   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONES_ON = CFG_IDX_W'(7);

  // register reset values
  localparam logic [GAIN_W-1:0]   RST_GAIN_P    = GAIN_W'(3932);
  localparam logic [GAIN_W-1:0]   RST_GAIN_I    = GAIN_W'(328);
  localparam logic [GAIN_W-1:0]   RST_GAIN_D    = GAIN_W'(32768);
  localparam logic [SMOOTH_W-1:0] RST_SMOOTHING = SMOOTH_W'(51);
  localparam logic [STIC_W-1:0]   RST_STICTION  = STIC_W'(55);
  localparam logic [LIM_W-1:0]    RST_INT_LIMIT = LIM_W'(6000);
  localparam logic [WIN_W-1:0]    RST_INT_WIN   = WIN_W'(200);

  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE    = SMOOTH_W'(256);
  localparam logic [ABS_W-1:0]    REST_ENTER_Q8 = ABS_W'(10 * 256);
  localparam logic [ABS_W-1:0]    REST_EXIT_Q8  = ABS_W'(25 * 256);
  localparam logic [ABS_W-1:0]    D_DEAD_Q8     = ABS_W'(25 * 256);
  localparam int                  SPEED_MAX     = 100;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_WS,
    MUL_WA,
    MUL_P,
    MUL_I,
    MUL_D
  } mfp_mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_EMA,
    ACC_PTERM,
    ACC_ADD
  } mfp_acc_op_e;

  typedef struct packed {
    logic         take;
    mfp_mul_sel_e mul_sel;
    mfp_acc_op_e  acc_op;
    logic         avg_init;
    logic         avg_upd;
    logic         err_upd;
    logic         decide;
    logic         commit;
    logic         fin;
  } mfp_cmd_t;

  typedef struct packed {
    logic run;
    logic out_free;
  } mfp_sts_t;

endpackage
`default_nettype wire

>>> hdl/mfp_ifs.sv
// Valid/ready channel interfaces: tick input, result output and register writes.
`default_nettype none
interface mfp_in_if import mfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] position_sample;
  logic [SAMPLE_W-1:0] target;
  logic                drive_enable;

  modport source (output valid, position_sample, target, drive_enable, input ready);
  modport sink (input valid, position_sample, target, drive_enable, output ready);
endinterface

interface mfp_out_if import mfp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] drive_speed;
  logic [DUTY_W-1:0]         duty_up;
  logic [DUTY_W-1:0]         duty_down;
  logic signed [PERR_W-1:0]  position_error;
  logic [SAMPLE_W-1:0]       filtered_position;
  logic                      at_rest;

  modport source (output valid, drive_speed, duty_up, duty_down, position_error,
                  filtered_position, at_rest, input ready);
  modport sink (input valid, drive_speed, duty_up, duty_down, position_error,
                filtered_position, at_rest, output ready);
endinterface

interface mfp_cfg_if import mfp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/mfp_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module mfp_mul import mfp_pkg::*; (
  input  logic                       clk_i,
  input  logic signed [MUL_A_W-1:0]  a_i,
  input  logic signed [MUL_B_W-1:0]  b_i,
  output logic signed [PROD_W-1:0]   p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> hdl/mfp_ctrl.sv
// Sequencer that steps the datapath through one control tick.
`default_nettype none
module mfp_ctrl import mfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mfp_sts_t sts_i,
  output mfp_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;
  localparam logic [3:0] ST_EMA   = 4'd2;
  localparam logic [3:0] ST_AVG   = 4'd3;
  localparam logic [3:0] ST_ERR   = 4'd4;
  localparam logic [3:0] ST_DEC   = 4'd5;
  localparam logic [3:0] ST_CLAMP = 4'd6;
  localparam logic [3:0] ST_MI    = 4'd7;
  localparam logic [3:0] ST_MD    = 4'd8;
  localparam logic [3:0] ST_SUM   = 4'd9;
  localparam logic [3:0] ST_FIN   = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.acc_op   = ACC_HOLD;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.avg_init = 1'b1;
        cmd_o.mul_sel  = MUL_WS;
        state_d        = ST_EMA;
      end
      ST_EMA: begin
        cmd_o.mul_sel = MUL_WA;
        cmd_o.acc_op  = ACC_EMA;
        state_d       = ST_AVG;
      end
      ST_AVG: begin
        cmd_o.avg_upd = 1'b1;
        state_d       = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.err_upd = 1'b1;
        state_d       = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.commit  = 1'b1;
        cmd_o.mul_sel = MUL_P;
        state_d       = sts_i.run ? ST_MI : ST_FIN;
      end
      ST_MI: begin
        cmd_o.mul_sel = MUL_I;
        cmd_o.acc_op  = ACC_PTERM;
        state_d       = ST_MD;
      end
      ST_MD: begin
        cmd_o.mul_sel = MUL_D;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/mfp_dp.sv
// Datapath: registers, EMA filter, error logic, PID terms and result register.
`default_nettype none
module mfp_dp import mfp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mfp_cmd_t                   cmd_i,
  output mfp_sts_t                   sts_o,
  input  logic [SAMPLE_W-1:0]        sample_i,
  input  logic [SAMPLE_W-1:0]        target_i,
  input  logic                       enable_i,
  input  logic                       cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [SPEED_W-1:0]  drive_speed_o,
  output logic [DUTY_W-1:0]          duty_up_o,
  output logic [DUTY_W-1:0]          duty_down_o,
  output logic signed [PERR_W-1:0]   position_error_o,
  output logic [SAMPLE_W-1:0]        filtered_position_o,
  output logic                       at_rest_o
);

  localparam logic signed [QUO_W-1:0] QUO_MAX = QUO_W'(SPEED_MAX);
  localparam logic signed [QUO_W-1:0] QUO_MIN = QUO_W'(-SPEED_MAX);

  // configuration
  logic [GAIN_W-1:0]   gain_p_q, gain_i_q, gain_d_q;
  logic [SMOOTH_W-1:0] smoothing_q;
  logic [STIC_W-1:0]   stiction_q;
  logic [LIM_W-1:0]    int_limit_q;
  logic [WIN_W-1:0]    int_window_q;
  logic                deadzones_q;

  // tick inputs
  logic [SAMPLE_W-1:0] sample_q, target_q;
  logic                enable_q;

  // loop state
  logic [AVG_W-1:0]         avg_q;
  logic signed [ESUM_W-1:0] esum_q;
  logic signed [ERR_W-1:0]  last_err_q;
  logic                     resting_q;

  // working registers
  logic signed [ERR_W-1:0]   e_q;
  logic signed [ESUM_W-1:0]  esum_tmp_q;
  logic signed [DERIV_W-1:0] deriv_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  // result register
  logic                      out_valid_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [DUTY_W-1:0]         duty_up_q, duty_down_q;
  logic signed [PERR_W-1:0]  perr_q;
  logic [SAMPLE_W-1:0]       filt_q;
  logic                      rest_out_q;

  logic [SMOOTH_W-1:0]       w, w_c;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext, stic_ext, avg_sum;
  logic signed [ERR_W-1:0]   e_d, e_neg, e_bias, e_adj;
  logic [ABS_W-1:0]          abs_e;
  logic [ERR_W-1:0]          win_q8;
  logic [LIM_W+Q8_SH-1:0]    lim;
  logic signed [ESUM_W-1:0]  lim_s, lim_neg, esum_add, esum_clamped;
  logic signed [ACC_W-1:0]   trunc_bias, acc_adj;
  logic signed [QUO_W-1:0]   quo;
  logic signed [SPEED_W-1:0] speed_sat, speed_d, speed_neg;
  logic                      run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q     <= RST_GAIN_P;
      gain_i_q     <= RST_GAIN_I;
      gain_d_q     <= RST_GAIN_D;
      smoothing_q  <= RST_SMOOTHING;
      stiction_q   <= RST_STICTION;
      int_limit_q  <= RST_INT_LIMIT;
      int_window_q <= RST_INT_WIN;
      deadzones_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_P:       gain_p_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:       gain_i_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:       gain_d_q     <= cfg_data_i[GAIN_W-1:0];
        REG_SMOOTHING:    smoothing_q  <= cfg_data_i[SMOOTH_W-1:0];
        REG_STICTION:     stiction_q   <= cfg_data_i[STIC_W-1:0];
        REG_INT_LIMIT:    int_limit_q  <= cfg_data_i[LIM_W-1:0];
        REG_INT_WINDOW:   int_window_q <= cfg_data_i[WIN_W-1:0];
        REG_DEADZONES_ON: deadzones_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // weights above one count as one
  assign w   = (smoothing_q > SMOOTH_ONE) ? SMOOTH_ONE : smoothing_q;
  assign w_c = SMOOTH_ONE - w;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_WS: begin
        mul_a = MUL_A_W'(w);
        mul_b = MUL_B_W'(sample_q);
      end
      MUL_WA: begin
        mul_a = MUL_A_W'(w_c);
        mul_b = MUL_B_W'(avg_q);
      end
      MUL_P: begin
        mul_a = MUL_A_W'(gain_p_q);
        mul_b = MUL_B_W'(e_q);
      end
      MUL_I: begin
        mul_a = MUL_A_W'(gain_i_q);
        mul_b = esum_q;
      end
      MUL_D: begin
        mul_a = MUL_A_W'(gain_d_q);
        mul_b = MUL_B_W'(deriv_q);
      end
      default: ;
    endcase
  end

  mfp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign prod_ext = ACC_W'(prod);
  assign stic_ext = $signed({{(ACC_W-STIC_W-Q24_SH){1'b0}}, stiction_q, {Q24_SH{1'b0}}});

  always_comb begin
    acc_d = acc_q;
    case (cmd_i.acc_op)
      ACC_HOLD:  acc_d = acc_q;
      ACC_EMA:   acc_d = prod_ext <<< Q8_SH;
      ACC_PTERM: begin
        // stiction pushes a nonzero P term further from zero
        if (prod == '0) begin
          acc_d = prod_ext;
        end else if (prod[PROD_W-1]) begin
          acc_d = prod_ext - stic_ext;
        end else begin
          acc_d = prod_ext + stic_ext;
        end
      end
      ACC_ADD:   acc_d = acc_q + prod_ext;
      default:   acc_d = acc_q;
    endcase
  end

  assign avg_sum = acc_q + prod_ext;

  assign e_d   = $signed({1'b0, target_q, {Q8_SH{1'b0}}}) - $signed({1'b0, avg_q});
  assign e_neg = -e_q;
  assign abs_e = e_q[ERR_W-1] ? e_neg[ABS_W-1:0] : e_q[ABS_W-1:0];

  assign win_q8   = {int_window_q, {Q8_SH{1'b0}}};
  assign esum_add = esum_q + ESUM_W'(e_q);

  assign lim     = (gain_i_q != '0) ? {int_limit_q, {Q8_SH{1'b0}}} : '0;
  assign lim_s   = $signed(ESUM_W'(lim));
  assign lim_neg = -lim_s;
  assign esum_clamped = (esum_tmp_q > lim_s)   ? lim_s :
                        (esum_tmp_q < lim_neg) ? lim_neg : esum_tmp_q;

  assign run = enable_q & ~resting_q;

  // truncate toward zero, then saturate
  assign trunc_bias = acc_q[ACC_W-1] ? ACC_W'((1 << Q24_SH) - 1) : '0;
  assign acc_adj    = acc_q + trunc_bias;
  assign quo        = acc_adj[ACC_W-1:Q24_SH];
  assign speed_sat  = (quo > QUO_MAX) ? SPEED_W'(SPEED_MAX) :
                      (quo < QUO_MIN) ? SPEED_W'(-SPEED_MAX) : SPEED_W'(quo);
  assign speed_d    = run ? speed_sat : '0;
  assign speed_neg  = -speed_d;

  assign e_bias = e_q[ERR_W-1] ? ERR_W'(255) : '0;
  assign e_adj  = e_q + e_bias;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sample_q <= sample_i;
      target_q <= target_i;
      enable_q <= enable_i;
    end
    acc_q <= acc_d;
    if (cmd_i.err_upd) begin
      e_q <= e_d;
    end
    if (cmd_i.decide) begin
      esum_tmp_q <= ({1'b0, abs_e} < win_q8) ? esum_add : '0;
      deriv_q    <= (deadzones_q && (abs_e < D_DEAD_Q8)) ? '0
                    : DERIV_W'(e_q) - DERIV_W'(last_err_q);
    end
    if (cmd_i.fin) begin
      speed_q     <= speed_d;
      duty_up_q   <= (speed_d > 0) ? speed_d[DUTY_W-1:0] : '0;
      duty_down_q <= (speed_d < 0) ? speed_neg[DUTY_W-1:0] : '0;
      perr_q      <= resting_q ? '0 : e_adj[ERR_W-1:Q8_SH];
      filt_q      <= avg_q[AVG_W-1:Q8_SH];
      rest_out_q  <= resting_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q       <= '0;
      esum_q      <= '0;
      last_err_q  <= '0;
      resting_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.avg_init) begin
        if (avg_q == '0) begin
          avg_q <= {sample_q, {Q8_SH{1'b0}}};
        end
      end else if (cmd_i.avg_upd) begin
        avg_q <= avg_sum[AVG_W+Q8_SH-1:Q8_SH];
      end
      if (cmd_i.decide && enable_q) begin
        if (!deadzones_q) begin
          resting_q <= 1'b0;
        end else if (!resting_q && (abs_e <= REST_ENTER_Q8)) begin
          resting_q <= 1'b1;
        end else if (resting_q && (abs_e > REST_EXIT_Q8)) begin
          resting_q <= 1'b0;
        end
      end
      if (cmd_i.commit && enable_q) begin
        if (resting_q) begin
          esum_q     <= '0;
          last_err_q <= '0;
        end else begin
          esum_q <= esum_clamped;
        end
      end
      if (cmd_i.fin && run) begin
        last_err_q <= e_q;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.run      = run;
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign drive_speed_o       = speed_q;
  assign duty_up_o           = duty_up_q;
  assign duty_down_o         = duty_down_q;
  assign position_error_o    = perr_q;
  assign filtered_position_o = filt_q;
  assign at_rest_o           = rest_out_q;

endmodule
`default_nettype wire

>>> hdl/motor_fader_pid_controller.sv
// Top level of the motor fader PID controller.
//
//  channel  dir  payload                                          transfer when
//  in_i     in   position_sample, target, drive_enable             valid & ready
//  out_o    out  drive_speed, duty_up, duty_down, position_error,  valid & ready
//                filtered_position, at_rest
//  cfg_i    in   index (register 0..7), data                       valid & ready
//
// After the input transfer the sequencer steps through LOAD, EMA, AVG, ERR, DEC and CLAMP,
// then MI, MD and SUM while the loop runs, and loads the result in FIN; MI, MD and SUM
// are skipped when the drive is disabled or the fader is resting. One multiplier is shared
// by the EMA and the three PID products, which sets the step count.
// The input is taken again as soon as the sequencer is idle, even while the last result
// waits in the output register; the sequencer only stalls if that result is still held.
// Reset clears the filter, integral, previous error and resting flag and loads the
// default register values. Register writes are always taken.
`default_nettype none
`include "motor_fader_pid_controller_macros.svh"
module motor_fader_pid_controller import mfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mfp_in_if.sink     in_i,
  mfp_cfg_if.sink    cfg_i,
  mfp_out_if.source  out_o
);

  mfp_cmd_t cmd;
  mfp_sts_t sts;
  logic     in_ready;

  mfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfp_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .sample_i            (in_i.position_sample),
    .target_i            (in_i.target),
    .enable_i            (in_i.drive_enable),
    .cfg_valid_i         (cfg_i.valid),
    .cfg_index_i         (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .out_ready_i         (out_o.ready),
    .out_valid_o         (out_o.valid),
    .drive_speed_o       (out_o.drive_speed),
    .duty_up_o           (out_o.duty_up),
    .duty_down_o         (out_o.duty_down),
    .position_error_o    (out_o.position_error),
    .filtered_position_o (out_o.filtered_position),
    .at_rest_o           (out_o.at_rest)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // one tick in flight: no new transfer straight after one is taken
  `MFP_ASSERT(a_busy_after_take, (in_i.valid && in_i.ready) |=> !in_i.ready)
  `MFP_ASSERT(a_fin_loads_result, cmd.fin |=> out_o.valid)
  // a result still held is never overwritten
  `MFP_ASSERT_NR(a_no_overwrite, cmd.fin |-> (!out_o.valid || out_o.ready))

endmodule
`default_nettype wire

>>> tb/tb_motor_fader_pid_controller.sv
`timescale 1ns / 100ps
// Self-checking testbench for the motor fader PID controller: random ticks, tracked model.
module tb_motor_fader_pid_controller;
  import mfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_TICKS  = 185;
  localparam int unsigned NUM_SETTINGS  = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] target;
    logic                enable;
  } fader_tick_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [DUTY_W-1:0]         up;
    logic [DUTY_W-1:0]         down;
    logic signed [PERR_W-1:0]  err;
    logic [SAMPLE_W-1:0]       filt;
    logic                      rest;
  } fader_result_t;

  logic clk;
  logic rst_n;

  mfp_in_if  tick_if ();
  mfp_cfg_if reg_if ();
  mfp_out_if res_if ();

  motor_fader_pid_controller i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (tick_if),
    .cfg_i  (reg_if),
    .out_o  (res_if)
  );

  // controller model: registers and loop state
  logic [GAIN_W-1:0]   kp, ki, kd;
  logic [SMOOTH_W-1:0] smooth_w;
  logic [STIC_W-1:0]   stiction;
  logic [LIM_W-1:0]    int_limit;
  logic [WIN_W-1:0]    int_window;
  logic                deadzones;
  logic [AVG_W-1:0]    avg_q8;
  longint              err_sum;
  longint              prev_err;
  logic                resting;

  fader_tick_t   tick_backlog[$];
  fader_result_t predicted_outputs[$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_rest_seen;
  int unsigned n_saturated;
  int unsigned n_settings;
  int unsigned cycle_cnt;
  int unsigned hold_left;
  logic        hold_kick;
  logic        hold_seen;

  function automatic fader_result_t advance_controller(fader_tick_t t);
    longint w, s, a, e, mag, lim, deriv, p_term, total, speed;
    fader_result_t r;
    w = (smooth_w > SMOOTH_ONE) ? 256 : smooth_w;
    s = t.sample;
    if (avg_q8 == '0) avg_q8 = AVG_W'(s * 256);
    a = avg_q8;
    a = (w * s * 256 + (256 - w) * a) / 256;
    avg_q8 = AVG_W'(a);
    e = longint'(t.target) * 256 - a;
    mag = (e < 0) ? -e : e;
    speed = 0;
    if (t.enable) begin
      if (deadzones) begin
        if (!resting && mag <= 10 * 256) resting = 1'b1;
        else if (resting && mag > 25 * 256) resting = 1'b0;
      end else begin
        resting = 1'b0;
      end
      if (resting) begin
        err_sum = 0;
        prev_err = 0;
      end else begin
        lim = (ki != '0) ? longint'(int_limit) * 256 : 0;
        if (mag < longint'(int_window) * 256) err_sum += e;
        else err_sum = 0;
        if (err_sum > lim) err_sum = lim;
        if (err_sum < -lim) err_sum = -lim;
        deriv = e - prev_err;
        if (deadzones && mag < 25 * 256) deriv = 0;
        p_term = longint'(kp) * e;
        // friction offset pushes a nonzero P term further from zero
        if (p_term > 0) p_term += longint'(stiction) * (longint'(1) << Q24_SH);
        else if (p_term < 0) p_term -= longint'(stiction) * (longint'(1) << Q24_SH);
        total = p_term + longint'(ki) * err_sum + longint'(kd) * deriv;
        speed = total / (longint'(1) << Q24_SH);
        if (speed > SPEED_MAX) speed = SPEED_MAX;
        if (speed < -SPEED_MAX) speed = -SPEED_MAX;
        prev_err = e;
      end
    end
    r.speed = SPEED_W'(speed);
    r.up    = (speed > 0) ? DUTY_W'(speed) : '0;
    r.down  = (speed < 0) ? DUTY_W'(-speed) : '0;
    r.err   = resting ? '0 : PERR_W'(e / 256);
    r.filt  = avg_q8[AVG_W-1:Q8_SH];
    r.rest  = resting;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:       kp = data[GAIN_W-1:0];
      REG_GAIN_I:       ki = data[GAIN_W-1:0];
      REG_GAIN_D:       kd = data[GAIN_W-1:0];
      REG_SMOOTHING:    smooth_w = data[SMOOTH_W-1:0];
      REG_STICTION:     stiction = data[STIC_W-1:0];
      REG_INT_LIMIT:    int_limit = data[LIM_W-1:0];
      REG_INT_WINDOW:   int_window = data[WIN_W-1:0];
      REG_DEADZONES_ON: deadzones = data[0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_result();
    fader_result_t want;
    if (predicted_outputs.size() == 0) begin
      report_mismatch("result with nothing pending, speed", res_if.drive_speed, 0);
      return;
    end
    want = predicted_outputs.pop_front();
    n_checked++;
    if (want.rest) n_rest_seen++;
    if (want.speed == SPEED_W'(SPEED_MAX) || want.speed == SPEED_W'(-SPEED_MAX)) n_saturated++;
    if (res_if.drive_speed !== want.speed)
      report_mismatch("drive_speed", res_if.drive_speed, want.speed);
    if (res_if.duty_up !== want.up)
      report_mismatch("duty_up", res_if.duty_up, want.up);
    if (res_if.duty_down !== want.down)
      report_mismatch("duty_down", res_if.duty_down, want.down);
    if (res_if.position_error !== want.err)
      report_mismatch("position_error", res_if.position_error, want.err);
    if (res_if.filtered_position !== want.filt)
      report_mismatch("filtered_position", res_if.filtered_position, want.filt);
    if (res_if.at_rest !== want.rest)
      report_mismatch("at_rest", res_if.at_rest, want.rest);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d ticks checked", cycle_cnt, n_checked,
               n_queued);
      $display("motor_fader_pid_controller verification failed");
      $finish;
    end
  end

  // long receiver hold-off, counted here so the sender keeps offering meanwhile
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // tick driver; prediction is taken at the transfer
  always @(posedge clk) begin : drive_ticks
    fader_tick_t nxt;
    fader_tick_t seen;
    if (!rst_n) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        seen.sample = tick_if.position_sample;
        seen.target = tick_if.target;
        seen.enable = tick_if.drive_enable;
        predicted_outputs.push_back(advance_controller(seen));
        n_accepted++;
      end
      if (!tick_if.valid || tick_if.ready) begin
        if (tick_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = tick_backlog.pop_front();
          tick_if.valid           <= 1'b1;
          tick_if.position_sample <= nxt.sample;
          tick_if.target          <= nxt.target;
          tick_if.drive_enable    <= nxt.enable;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) check_result();
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  function automatic logic [SAMPLE_W-1:0] fit12(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return SAMPLE_W'(v);
  endfunction

  function automatic void queue_tick(int sample, int target, logic enable);
    fader_tick_t t;
    t.sample = fit12(sample);
    t.target = fit12(target);
    t.enable = enable;
    tick_backlog.push_back(t);
    n_queued++;
  endfunction

  // mostly settling moves of the fader toward a setpoint, some plain noise
  function automatic void queue_random_ticks(int count);
    int left, burst, pos, tgt, spread, pull, jitter, i;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9) == 0) begin
        queue_tick($urandom_range(4095), $urandom_range(4095), $urandom_range(1));
        left--;
      end else begin
        case ($urandom_range(3))
          0:       spread = 8;
          1:       spread = 40;
          2:       spread = 400;
          default: spread = 4095;
        endcase
        tgt = ($urandom_range(9) == 0) ? 4095 * int'($urandom_range(1))
                                        : int'($urandom_range(4095));
        pos = int'(fit12(tgt + int'($urandom_range(2 * spread)) - spread));
        burst = $urandom_range(30, 8);
        for (i = 0; i < burst && left > 0; i++) begin
          queue_tick(pos, tgt, $urandom_range(19) != 0);
          left--;
          pull = $urandom_range(60);
          jitter = int'($urandom_range(6)) - 3;
          pos = int'(fit12(pos + (tgt - pos) * pull / 100 + jitter));
        end
      end
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                           input int unsigned width);
    logic [CFG_DATA_W-1:0] data;
    // bits above the register width are random and must be ignored
    data = CFG_DATA_W'(($urandom << width) | value);
    @(posedge clk);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= data;
    do @(posedge clk); while (!reg_if.ready);
    reg_if.valid <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic write_all(input int unsigned p, i, d, sm, st, lim, win, dz);
    write_reg(REG_GAIN_P, p, GAIN_W);
    write_reg(REG_GAIN_I, i, GAIN_W);
    write_reg(REG_GAIN_D, d, GAIN_W);
    write_reg(REG_SMOOTHING, sm, SMOOTH_W);
    write_reg(REG_STICTION, st, STIC_W);
    write_reg(REG_INT_LIMIT, lim, LIM_W);
    write_reg(REG_INT_WINDOW, win, WIN_W);
    write_reg(REG_DEADZONES_ON, dz, 1);
    n_settings++;
  endtask

  function automatic int unsigned pick_gain();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 20'hFFFFF;
      2:       return $urandom_range(70000);
      default: return $urandom_range(20'hFFFFF);
    endcase
  endfunction

  task automatic load_setting(input int k);
    case (k)
      1:  write_all(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_SMOOTHING, RST_STICTION,
                    RST_INT_LIMIT, RST_INT_WIN, 1);
      2:  write_all(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 256, 100, 20'hFFFFF, 4096, 1);
      3:  write_all(0, 0, 0, 0, 0, 0, 0, 0);
      // no integral gain with a wide clamp, weight over one, oversized friction offset
      4:  write_all(RST_GAIN_P, 0, RST_GAIN_D, 300, 127, 20'hFFFFF, 8191, 1);
      10: write_all(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, RST_SMOOTHING, RST_STICTION,
                    RST_INT_LIMIT, RST_INT_WIN, 0);
      default:
        write_all(pick_gain(), pick_gain(), pick_gain(),
                  ($urandom_range(4) == 0) ? $urandom_range(511) : $urandom_range(256),
                  $urandom_range(127),
                  $urandom_range(1) ? $urandom_range(3000) : $urandom_range(20'hFFFFF),
                  ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(400),
                  $urandom_range(1));
    endcase
  endtask

  task automatic drain();
    while (n_checked != n_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int ph;
    rst_n = 1'b0;
    tick_if.valid = 1'b0;
    tick_if.position_sample = '0;
    tick_if.target = '0;
    tick_if.drive_enable = 1'b0;
    reg_if.valid = 1'b0;
    reg_if.index = '0;
    reg_if.data = '0;
    res_if.ready = 1'b0;
    hold_kick = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    cycle_cnt = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    kp = RST_GAIN_P;
    ki = RST_GAIN_I;
    kd = RST_GAIN_D;
    smooth_w = RST_SMOOTHING;
    stiction = RST_STICTION;
    int_limit = RST_INT_LIMIT;
    int_window = RST_INT_WIN;
    deadzones = 1'b0;
    avg_q8 = '0;
    err_sum = 0;
    prev_err = 0;
    resting = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: field extremes, filter reload from zero, drive off
    queue_tick(0, 0, 1);
    queue_tick(0, 0, 1);
    queue_tick(4095, 0, 1);
    queue_tick(4095, 4095, 1);
    queue_tick(0, 4095, 1);
    queue_tick(0, 4095, 0);
    queue_tick(2048, 2048, 0);
    queue_tick(2048, 2048, 1);
    queue_tick(2050, 2048, 1);
    queue_tick(2040, 2048, 1);
    queue_tick(4095, 4095, 1);
    queue_tick(0, 0, 1);
    drain();

    for (ph = 1; ph <= NUM_SETTINGS; ph++) begin
      load_setting(ph);
      case (ph % 4)
        0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1:       begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 9;  snk_stall_pct = 9;  end
      endcase
      if (ph == 1) begin
        // resting hysteresis: settle in, hold with drive off, leave, come back
        queue_tick(2000, 2000, 1);
        queue_tick(2000, 2000, 1);
        queue_tick(2000, 2000, 1);
        queue_tick(2000, 2000, 0);
        queue_tick(2000, 2040, 1);
        queue_tick(2000, 2020, 1);
        queue_tick(2000, 2005, 1);
        queue_tick(2000, 2020, 1);
        queue_tick(2000, 2030, 0);
      end
      if (ph == 4) hold_kick = ~hold_kick;
      queue_random_ticks(RANDOM_TICKS);
      drain();
    end

    $display("%0d ticks sent, %0d checked over %0d register settings after reset values",
             n_accepted, n_checked, n_settings);
    $display("%0d resting results, %0d saturated speeds", n_rest_seen, n_saturated);
    if (n_errors == 0) begin
      $display("motor_fader_pid_controller verification clean");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("motor_fader_pid_controller verification failed");
    end
    $finish;
  end

endmodule
